### rtl/gfba_pkg.sv
// Shared types and constants for the grouped free-block allocator.
`timescale 1ns / 1ps
package gfba_pkg;

  localparam int unsigned BLK_W = 10;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef enum logic [1:0] {
    SHIFT_HOLD,
    SHIFT_DOWN,
    SHIFT_UP
  } shift_e;

  typedef struct packed {
    shift_e           shift;
    logic [BLK_W-1:0] ins;
  } chain_ctl_t;

endpackage

### rtl/gfba_cell.sv
// One stack cell: holds a block number, takes it from a neighbor on a shift.
`timescale 1ns / 1ps
module gfba_cell import gfba_pkg::*; (
  input  logic             clk_i,
  input  shift_e           shift_i,
  input  logic [BLK_W-1:0] prev_i,
  input  logic [BLK_W-1:0] next_i,
  output logic [BLK_W-1:0] entry_o
);

  logic [BLK_W-1:0] entry_q;
  logic [BLK_W-1:0] entry_d;

  always_comb begin
    case (shift_i)
      SHIFT_DOWN: entry_d = prev_i;
      SHIFT_UP:   entry_d = next_i;
      default:    entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### rtl/gfba_chain.sv
// Row of stack cells; cell 0 is the top of stack, the last cell the bottom.
`timescale 1ns / 1ps
module gfba_chain import gfba_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic             clk_i,
  input  chain_ctl_t       ctl_i,
  output logic [BLK_W-1:0] head_o,
  output logic [BLK_W-1:0] tail_o
);

  logic [BLK_W-1:0] entry [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [BLK_W-1:0] prev;
    logic [BLK_W-1:0] next;

    if (i == 0) begin : g_first
      assign prev = ctl_i.ins;
    end else begin : g_mid_prev
      assign prev = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next = entry[i];
    end else begin : g_mid_next
      assign next = entry[i+1];
    end

    gfba_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (ctl_i.shift),
      .prev_i  (prev),
      .next_i  (next),
      .entry_o (entry[i])
    );
  end

  assign head_o = entry[0];
  assign tail_o = entry[DEPTH-1];

endmodule

### rtl/grouped_free_block_allocator.sv
// Grouped free-block allocator: stack of cells, group image memory, control.
// Push and pop: result registered (held if output stalls); one item per cycle if in_ready_o.
// Spill on a free into a full stack: the freed block's image is written, one word per cycle.
// Reload on taking the last entry: the stack refills through the image read port.
// Reset clears fill, total, control and output valid; stack cells and images need no clearing.
`timescale 1ns / 1ps
module grouped_free_block_allocator import gfba_pkg::*; #(
  parameter int unsigned GROUP      = 64,
  parameter int unsigned NUM_BLOCKS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             mode_i,
  input  logic [BLK_W-1:0] block_number_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [BLK_W-1:0] given_block_o,
  output logic             status_o
);

  localparam int unsigned GW         = $clog2(GROUP);
  localparam int unsigned FW         = $clog2(GROUP + 1);
  localparam int unsigned TW         = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned IMG_BLOCKS = (NUM_BLOCKS < (2 ** BLK_W)) ? NUM_BLOCKS : (2 ** BLK_W);
  localparam int unsigned IB_W       = $clog2(IMG_BLOCKS);
  localparam int unsigned AW         = IB_W + GW;
  localparam int unsigned MEM_DEPTH  = IMG_BLOCKS * (2 ** GW);

  localparam logic [GW-1:0] CNT_LAST   = GW'(GROUP - 1);
  localparam logic [FW-1:0] FILL_FULL  = FW'(GROUP);
  localparam logic [FW-1:0] FILL_ONE   = FW'(1);
  localparam logic [TW-1:0] TOTAL_MAX  = TW'(NUM_BLOCKS);
  localparam logic [TW-1:0] TOTAL_ONE  = TW'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPILL,
    ST_LOAD,
    ST_LOAD_LAST
  } state_e;

  state_e           state_q, state_d;
  logic [GW-1:0]    cnt_q, cnt_d;
  logic [FW-1:0]    fill_q, fill_d;
  logic [TW-1:0]    total_q, total_d;
  logic             out_valid_q, out_valid_d;
  logic [BLK_W-1:0] out_block_q, out_block_d;
  logic             out_status_q, out_status_d;
  logic             held_valid_q, held_valid_d;
  logic [BLK_W-1:0] held_block_q, held_block_d;
  logic             held_status_q, held_status_d;
  logic             rd_valid_q, rd_valid_d;
  logic [IB_W-1:0]  img_blk_q, img_blk_d;
  logic [BLK_W-1:0] rd_data_q;

  logic [BLK_W-1:0] img_mem [MEM_DEPTH];
  logic [AW-1:0]    mem_addr;
  logic             mem_we;

  chain_ctl_t       ctl;
  logic [BLK_W-1:0] head;
  logic [BLK_W-1:0] tail;

  logic             accept;
  logic             out_free;
  logic             blk_ok;
  logic             head_ok;
  logic [BLK_W-1:0] res_block;
  logic             res_status;

  gfba_chain #(
    .DEPTH (GROUP)
  ) u_chain (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .head_o (head),
    .tail_o (tail)
  );

  assign in_ready_o = (state_q == ST_IDLE) && !held_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign blk_ok     = 32'(block_number_i) < NUM_BLOCKS;
  assign head_ok    = 32'(head) < NUM_BLOCKS;
  assign mem_addr   = {img_blk_q, cnt_q};

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    fill_d        = fill_q;
    total_d       = total_q;
    out_valid_d   = out_valid_q;
    out_block_d   = out_block_q;
    out_status_d  = out_status_q;
    held_valid_d  = held_valid_q;
    held_block_d  = held_block_q;
    held_status_d = held_status_q;
    img_blk_d     = img_blk_q;
    rd_valid_d    = 1'b0;
    mem_we        = 1'b0;
    ctl           = '{shift: SHIFT_HOLD, ins: '0};
    res_block     = '0;
    res_status    = STATUS_OK;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (mode_i == MODE_ALLOC) begin
            if (total_q == '0 || fill_q == '0) begin
              res_status = STATUS_EMPTY;
            end else if (fill_q == FILL_ONE) begin
              res_block = head;
              total_d   = total_q - TOTAL_ONE;
              if (total_q == TOTAL_ONE || !head_ok) begin
                fill_d = '0;
              end else begin
                fill_d    = FILL_FULL;
                img_blk_d = head[IB_W-1:0];
                cnt_d     = '0;
                state_d   = ST_LOAD;
              end
            end else begin
              res_block = head;
              total_d   = total_q - TOTAL_ONE;
              fill_d    = fill_q - FILL_ONE;
              ctl       = '{shift: SHIFT_UP, ins: '0};
            end
          end else if (blk_ok) begin
            if (fill_q >= FILL_FULL) begin
              img_blk_d = block_number_i[IB_W-1:0];
              cnt_d     = '0;
              fill_d    = FILL_ONE;
              state_d   = ST_SPILL;
            end else begin
              fill_d = fill_q + FILL_ONE;
              ctl    = '{shift: SHIFT_DOWN, ins: block_number_i};
            end
            if (total_q < TOTAL_MAX) begin
              total_d = total_q + TOTAL_ONE;
            end
          end
        end
      end
      ST_SPILL: begin
        mem_we = 1'b1;
        ctl    = '{shift: SHIFT_DOWN, ins: BLK_W'(img_blk_q)};
        cnt_d  = cnt_q + GW'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_LOAD: begin
        rd_valid_d = 1'b1;
        cnt_d      = cnt_q + GW'(1);
        if (rd_valid_q) begin
          ctl = '{shift: SHIFT_DOWN, ins: rd_data_q};
        end
        if (cnt_q == CNT_LAST) begin
          state_d = ST_LOAD_LAST;
        end
      end
      ST_LOAD_LAST: begin
        if (rd_valid_q) begin
          ctl = '{shift: SHIFT_DOWN, ins: rd_data_q};
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (held_valid_q && out_free) begin
      out_valid_d  = 1'b1;
      out_block_d  = held_block_q;
      out_status_d = held_status_q;
      held_valid_d = 1'b0;
    end else if (accept) begin
      if (out_free) begin
        out_valid_d  = 1'b1;
        out_block_d  = res_block;
        out_status_d = res_status;
      end else begin
        held_valid_d  = 1'b1;
        held_block_d  = res_block;
        held_status_d = res_status;
      end
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      fill_q        <= '0;
      total_q       <= '0;
      out_valid_q   <= 1'b0;
      out_block_q   <= '0;
      out_status_q  <= STATUS_OK;
      held_valid_q  <= 1'b0;
      held_block_q  <= '0;
      held_status_q <= STATUS_OK;
      rd_valid_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      fill_q        <= fill_d;
      total_q       <= total_d;
      out_valid_q   <= out_valid_d;
      out_block_q   <= out_block_d;
      out_status_q  <= out_status_d;
      held_valid_q  <= held_valid_d;
      held_block_q  <= held_block_d;
      held_status_q <= held_status_d;
      rd_valid_q    <= rd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    img_blk_q <= img_blk_d;
    if (mem_we) begin
      img_mem[mem_addr] <= tail;
    end
    rd_data_q <= img_mem[mem_addr];
  end

  assign out_valid_o   = out_valid_q;
  assign given_block_o = out_block_q;
  assign status_o      = out_status_q;

endmodule

### tb/grouped_free_block_allocator_test.sv
// Self-checking bench for the grouped free-block allocator: directed table, then random runs.
`timescale 1ns / 1ps
module grouped_free_block_allocator_test;
  import gfba_pkg::*;

  localparam int unsigned GROUP        = 64;
  localparam int unsigned NUM_BLOCKS   = 1024;
  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 2 * GROUP + 16;
  localparam int unsigned MAX_IDLE     = 18;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned LONG_HOLD    = 600;
  localparam int unsigned N_ROWS       = 18;

  typedef struct {
    logic [BLK_W-1:0] given;
    logic             status;
  } grant_t;

  typedef struct {
    mode_e            op;
    logic [BLK_W-1:0] blk;
    bit               typed;
    logic [BLK_W-1:0] given;
    logic             status;
  } step_row_t;

  localparam grant_t NO_GRANT = '{given: '0, status: STATUS_OK};

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             mode_i;
  logic [BLK_W-1:0] block_number_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [BLK_W-1:0] given_block_o;
  logic             status_o;

  logic [BLK_W-1:0] stack_m [GROUP];
  logic [BLK_W-1:0] image_m [NUM_BLOCKS][GROUP];
  bit               image_valid [NUM_BLOCKS];
  int unsigned      fill_m;
  int unsigned      total_m;

  grant_t      pending_grants [$];
  grant_t      oldest_grant;
  int unsigned fails = 0;
  int unsigned cycles = 0;
  int unsigned sent_items = 0;
  bit          send_idle = 1'b1;

  step_row_t directed_rows [N_ROWS] = '{
    '{MODE_ALLOC, 10'h000, 1'b1, 10'h000, STATUS_EMPTY},
    '{MODE_ALLOC, 10'h3FF, 1'b1, 10'h000, STATUS_EMPTY},
    '{MODE_FREE,  10'h000, 1'b1, 10'h000, STATUS_OK},
    '{MODE_ALLOC, 10'h3FF, 1'b1, 10'h000, STATUS_OK},
    '{MODE_ALLOC, 10'h000, 1'b1, 10'h000, STATUS_EMPTY},
    '{MODE_FREE,  10'h3FF, 1'b1, 10'h000, STATUS_OK},
    '{MODE_FREE,  10'h000, 1'b1, 10'h000, STATUS_OK},
    '{MODE_FREE,  10'h2AA, 1'b1, 10'h000, STATUS_OK},
    '{MODE_FREE,  10'h155, 1'b1, 10'h000, STATUS_OK},
    '{MODE_ALLOC, 10'h2AA, 1'b1, 10'h155, STATUS_OK},
    '{MODE_ALLOC, 10'h155, 1'b1, 10'h2AA, STATUS_OK},
    '{MODE_FREE,  10'h001, 1'b0, 10'h000, STATUS_OK},
    '{MODE_FREE,  10'h200, 1'b0, 10'h000, STATUS_OK},
    '{MODE_ALLOC, 10'h3FF, 1'b0, 10'h000, STATUS_OK},
    '{MODE_ALLOC, 10'h000, 1'b0, 10'h000, STATUS_OK},
    '{MODE_ALLOC, 10'h1FF, 1'b0, 10'h000, STATUS_OK},
    '{MODE_ALLOC, 10'h000, 1'b1, 10'h3FF, STATUS_OK},
    '{MODE_ALLOC, 10'h3FF, 1'b1, 10'h000, STATUS_EMPTY}
  };

  grouped_free_block_allocator #(
    .GROUP      (GROUP),
    .NUM_BLOCKS (NUM_BLOCKS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .block_number_i (block_number_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .given_block_o  (given_block_o),
    .status_o       (status_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic grant_t alloc_predict(input mode_e op, input logic [BLK_W-1:0] blk);
    grant_t g;
    g = NO_GRANT;
    if (op == MODE_ALLOC) begin
      if (total_m == 0 || fill_m == 0 || fill_m > GROUP) begin
        g.status = STATUS_EMPTY;
      end else if (fill_m == 1) begin
        g.given = stack_m[0];
        total_m--;
        if (total_m == 0 || g.given >= NUM_BLOCKS) begin
          fill_m = 0;
        end else begin
          for (int i = 0; i < GROUP; i++) stack_m[i] = image_m[g.given][i];
          fill_m = GROUP;
        end
      end else begin
        fill_m--;
        total_m--;
        g.given = stack_m[fill_m];
      end
    end else if (blk < NUM_BLOCKS) begin
      if (fill_m >= GROUP) begin
        for (int i = 0; i < GROUP; i++) image_m[blk][i] = stack_m[i];
        image_valid[blk] = 1'b1;
        stack_m[0] = blk;
        fill_m = 1;
      end else begin
        stack_m[fill_m] = blk;
        fill_m++;
      end
      if (total_m < NUM_BLOCKS) total_m++;
    end
    return g;
  endfunction

  function automatic bit hits_blank_image();
    return total_m > 1 && fill_m == 1 && !image_valid[stack_m[0]];
  endfunction

  task automatic offer_item(input mode_e op, input logic [BLK_W-1:0] blk, input bit typed,
                            input grant_t fixed);
    grant_t      g;
    int unsigned gap;
    g = alloc_predict(op, blk);
    if (typed) pending_grants.push_back(fixed);
    else pending_grants.push_back(g);
    gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= op;
    block_number_i <= blk;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_items++;
    if (sent_items % 64 == 0) send_idle = ($urandom_range(0, 3) != 0);
  endtask

  task automatic random_item(input int unsigned free_pct);
    mode_e            op;
    logic [BLK_W-1:0] blk;
    op  = ($urandom_range(0, 99) < free_pct) ? MODE_FREE : MODE_ALLOC;
    blk = BLK_W'($urandom_range(0, NUM_BLOCKS - 1));
    if (op == MODE_ALLOC && hits_blank_image()) op = MODE_FREE;
    offer_item(op, blk, 1'b0, NO_GRANT);
  endtask

  initial begin
    grant_t      row_grant;
    int unsigned run_len;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    mode_i         = 1'b0;
    block_number_i = '0;
    fill_m         = 0;
    total_m        = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      row_grant.given  = directed_rows[r].given;
      row_grant.status = directed_rows[r].status;
      offer_item(directed_rows[r].op, directed_rows[r].blk, directed_rows[r].typed, row_grant);
    end

    // push past a spill, then pop back through the reload
    run_len = $urandom_range(GROUP + 24, 2 * GROUP + 16);
    repeat (run_len) random_item(90);
    repeat (run_len + 8) random_item(10);
    repeat (60) random_item(50);
    // climb to a saturated total, then drain across several reloads
    while (total_m < NUM_BLOCKS) random_item(97);
    repeat (40) random_item(90);
    repeat (250) random_item(8);

    in_valid_i <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned hold;
    int unsigned taken;
    bit          recv_idle;
    hold        = 0;
    taken       = 0;
    recv_idle   = 1'b1;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ready_i && out_valid_o) begin
        taken++;
        if (taken % 50 == 0) recv_idle = ($urandom_range(0, 3) != 0);
        if (taken == HOLD_AT) hold = LONG_HOLD;
        else hold = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (hold > 0) out_ready_i <= 1'b0;
      end else if (!out_ready_i) begin
        if (hold > 0) hold--;
        if (hold == 0) out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual given_block %0d status %0d",
                 $time, given_block_o, status_o);
        fails++;
      end else begin
        oldest_grant = pending_grants.pop_front();
        if (given_block_o !== oldest_grant.given) begin
          $display("%0t: given_block expected %0d actual %0d",
                   $time, oldest_grant.given, given_block_o);
          fails++;
        end
        if (status_o !== oldest_grant.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, oldest_grant.status, status_o);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
